/* rtl/stt_pkg.sv */
package stt_pkg;

    // Register indexes of the configuration port.
    localparam logic REG_SPECIAL_LOW  = 1'b0;
    localparam logic REG_SPECIAL_HIGH = 1'b1;

    localparam logic [63:0] SPECIAL_LOW_RESET  = 64'd864708720641180672;
    localparam logic [63:0] SPECIAL_HIGH_RESET = 64'd2882303761517117440;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam int CLS_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    // One text byte after classification.
    typedef struct packed {
        logic [7:0] value;
        logic       is_zero;
        logic       is_special;
        logic       is_space;
        logic       is_newline;
        logic       is_slash;
        logic       is_star;
    } class_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  token_byte;
        logic        token_first;
        logic        token_last;
        logic [15:0] line_number;
        logic        text_done;
    } res_t;

    // Up to two results produced while scanning one byte.
    typedef struct packed {
        res_t [1:0] slot;
        logic [1:0] count;
    } pair_t;

    // Scanner state apart from the line counter.
    typedef struct packed {
        logic [7:0] held_byte;
        logic       held_valid;
        logic       held_first;
        logic       in_token;
        logic       in_line_cmt;
        logic       in_block_cmt;
        logic       star_seen;
        logic       slash_pend;
        logic       done_pend;
    } scan_t;

    localparam scan_t SCAN_IDLE = '0;

    function automatic res_t make_res(input logic [7:0] b, input logic first,
                                      input logic last, input logic done,
                                      input logic [15:0] line);
        res_t r;
        r.token_byte  = b;
        r.token_first = first;
        r.token_last  = last;
        r.line_number = line;
        r.text_done   = done;
        return r;
    endfunction

    // Appends a result to the pair; a third result is dropped.
    function automatic pair_t put_res(input pair_t p, input res_t r);
        pair_t q;
        q = p;
        if (q.count != 2'd2)
        begin
            q.slot[q.count[0]] = r;
            q.count = q.count + 2'd1;
        end
        return q;
    endfunction

endpackage

/* rtl/stt_fifo.sv */
module stt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en0,
    input  logic [WIDTH-1:0]           wr_data0,
    input  logic                       wr_en1,
    input  logic [WIDTH-1:0]           wr_data1,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    // The second write port is only used together with the first one.
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    wr_num;

    assign wr_num      = CW'(wr_en0) + CW'(wr_en1);
    assign wr_ptr_next = wr_ptr_reg + AW'(wr_num);
    assign rd_ptr_next = rd_ptr_reg + AW'(rd_en);
    assign count_next  = count_reg + wr_num - CW'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= wr_data1;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

/* rtl/stt_front.sv */
module stt_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  push,
    input  logic [7:0]            text_byte,
    output logic                  full,
    output logic                  cls_valid,
    output stt_pkg::class_t       cls_item,
    input  logic                  cls_pop
);

    localparam int CW = $clog2(stt_pkg::CLS_DEPTH) + 1;

    logic [63:0]       special_low_reg;
    logic [63:0]       special_high_reg;
    stt_pkg::class_t   cls_in;
    logic              accept;
    logic [CW-1:0]     cls_count;
    logic [$bits(stt_pkg::class_t)-1:0] cls_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            special_low_reg  <= stt_pkg::SPECIAL_LOW_RESET;
            special_high_reg <= stt_pkg::SPECIAL_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stt_pkg::REG_SPECIAL_LOW:  special_low_reg  <= cfg_data;
                stt_pkg::REG_SPECIAL_HIGH: special_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bytes from 128 up are never special.
    always_comb
    begin
        cls_in.value      = text_byte;
        cls_in.is_zero    = (text_byte == 8'h00);
        cls_in.is_special = !text_byte[7] &&
                            (text_byte[6] ? special_high_reg[text_byte[5:0]]
                                          : special_low_reg[text_byte[5:0]]);
        cls_in.is_space   = (text_byte == stt_pkg::CH_SPACE) ||
                            ((text_byte >= stt_pkg::CH_TAB) &&
                             (text_byte <= stt_pkg::CH_CR));
        cls_in.is_newline = (text_byte == stt_pkg::CH_NEWLINE);
        cls_in.is_slash   = (text_byte == stt_pkg::CH_SLASH);
        cls_in.is_star    = (text_byte == stt_pkg::CH_STAR);
    end

    assign full   = (cls_count == CW'(stt_pkg::CLS_DEPTH));
    assign accept = push && !full;

    stt_fifo #(
        .WIDTH ($bits(stt_pkg::class_t)),
        .DEPTH (stt_pkg::CLS_DEPTH)
    ) u_cls_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en0   (accept),
        .wr_data0 (cls_in),
        .wr_en1   (1'b0),
        .wr_data1 ('0),
        .rd_en    (cls_pop),
        .rd_data  (cls_raw),
        .count    (cls_count)
    );

    assign cls_item  = stt_pkg::class_t'(cls_raw);
    assign cls_valid = (cls_count != '0);

endmodule

/* rtl/stt_back.sv */
module stt_back #(
    parameter int LINE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cls_valid,
    input  stt_pkg::class_t   cls_item,
    output logic              cls_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        token_byte,
    output logic              token_first,
    output logic              token_last,
    output logic [15:0]       line_number,
    output logic              text_done
);

    localparam int WIDE = LINE_BITS + 16;
    localparam int CW   = $clog2(stt_pkg::RES_DEPTH) + 1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    stt_pkg::scan_t          st_reg;
    stt_pkg::scan_t          st_next;
    logic [LINE_BITS-1:0]    line_reg;
    logic [LINE_BITS-1:0]    line_next;
    stt_pkg::pair_t          rp;
    logic                    first;
    logic                    fire;
    logic [CW-1:0]           res_count;
    logic [CW-1:0]           res_free;
    logic [$bits(stt_pkg::res_t)-1:0] res_raw;
    stt_pkg::res_t           head;

    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [WIDE-1:0] w;
        w = {{16{1'b0}}, v};
        if (w > WIDE'(16'hFFFF))
        begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] line_up(input logic [LINE_BITS-1:0] v);
        if (v != '1)
        begin
            return v + LINE_ONE;
        end
        return v;
    endfunction

    always_comb
    begin
        st_next   = st_reg;
        line_next = line_reg;
        rp        = '0;
        first     = 1'b0;

        // A pending end of text leaves before anything else.
        if (st_next.done_pend)
        begin
            rp = stt_pkg::put_res(rp, stt_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b1,
                                                        sat_line(line_next)));
            st_next   = stt_pkg::SCAN_IDLE;
            line_next = LINE_ONE;
        end

        if (st_next.in_line_cmt)
        begin
            if (cls_item.is_zero)
            begin
                st_next.done_pend = 1'b1;
            end
            else if (cls_item.is_newline)
            begin
                line_next = line_up(line_next);
                st_next.in_line_cmt = 1'b0;
            end
        end
        else if (st_next.in_block_cmt)
        begin
            if (cls_item.is_zero)
            begin
                st_next.done_pend = 1'b1;
            end
            else if (cls_item.is_newline)
            begin
                line_next = line_up(line_next);
                st_next.star_seen = 1'b0;
            end
            else if (st_next.star_seen && cls_item.is_slash)
            begin
                st_next.in_block_cmt = 1'b0;
                st_next.star_seen    = 1'b0;
            end
            else
            begin
                st_next.star_seen = cls_item.is_star;
            end
        end
        else if (st_next.slash_pend && (cls_item.is_slash || cls_item.is_star))
        begin
            // The slash opens a comment and closes any word in progress.
            st_next.slash_pend = 1'b0;
            if (st_next.held_valid)
            begin
                rp = stt_pkg::put_res(rp, stt_pkg::make_res(st_next.held_byte,
                         st_next.held_first, 1'b1, 1'b0, sat_line(line_next)));
            end
            st_next.held_valid   = 1'b0;
            st_next.in_token     = 1'b0;
            st_next.in_line_cmt  = cls_item.is_slash;
            st_next.in_block_cmt = cls_item.is_star;
            st_next.star_seen    = 1'b0;
        end
        else
        begin
            // A slash that opened no comment becomes a word byte.
            if (st_next.slash_pend)
            begin
                st_next.slash_pend = 1'b0;
                first = !(st_next.held_valid && st_next.in_token);
                if (st_next.held_valid)
                begin
                    rp = stt_pkg::put_res(rp, stt_pkg::make_res(st_next.held_byte,
                             st_next.held_first, !st_next.in_token, 1'b0,
                             sat_line(line_next)));
                end
                st_next.held_byte  = stt_pkg::CH_SLASH;
                st_next.held_first = first;
                st_next.in_token   = 1'b1;
                st_next.held_valid = 1'b1;
            end

            if (cls_item.is_zero || cls_item.is_special || cls_item.is_space)
            begin
                if (st_next.held_valid)
                begin
                    rp = stt_pkg::put_res(rp, stt_pkg::make_res(st_next.held_byte,
                             st_next.held_first, 1'b1, 1'b0, sat_line(line_next)));
                end
                st_next.held_valid = 1'b0;
                st_next.in_token   = 1'b0;
                if (cls_item.is_zero)
                begin
                    st_next.done_pend = 1'b1;
                end
                else
                begin
                    if (cls_item.is_newline)
                    begin
                        line_next = line_up(line_next);
                    end
                    if (cls_item.is_special)
                    begin
                        st_next.held_byte  = cls_item.value;
                        st_next.held_first = 1'b1;
                        st_next.held_valid = 1'b1;
                    end
                end
            end
            else if (cls_item.is_slash)
            begin
                st_next.slash_pend = 1'b1;
            end
            else
            begin
                first = !(st_next.held_valid && st_next.in_token);
                if (st_next.held_valid)
                begin
                    rp = stt_pkg::put_res(rp, stt_pkg::make_res(st_next.held_byte,
                             st_next.held_first, !st_next.in_token, 1'b0,
                             sat_line(line_next)));
                end
                st_next.held_byte  = cls_item.value;
                st_next.held_first = first;
                st_next.in_token   = 1'b1;
                st_next.held_valid = 1'b1;
            end
        end

        // End of text goes out now unless both result slots are taken.
        if (st_next.done_pend && (rp.count != 2'd2))
        begin
            rp = stt_pkg::put_res(rp, stt_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b1,
                                                        sat_line(line_next)));
            st_next   = stt_pkg::SCAN_IDLE;
            line_next = LINE_ONE;
        end
    end

    assign res_free = CW'(stt_pkg::RES_DEPTH) - res_count;
    assign fire     = cls_valid && (CW'(rp.count) <= res_free);
    assign cls_pop  = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= stt_pkg::SCAN_IDLE;
            line_reg <= LINE_ONE;
        end
        else if (fire)
        begin
            st_reg   <= st_next;
            line_reg <= line_next;
        end
    end

    stt_fifo #(
        .WIDTH ($bits(stt_pkg::res_t)),
        .DEPTH (stt_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en0   (fire && (rp.count != 2'd0)),
        .wr_data0 (rp.slot[0]),
        .wr_en1   (fire && (rp.count == 2'd2)),
        .wr_data1 (rp.slot[1]),
        .rd_en    (pop && !empty),
        .rd_data  (res_raw),
        .count    (res_count)
    );

    assign head        = stt_pkg::res_t'(res_raw);
    assign empty       = (res_count == '0);
    assign token_byte  = head.token_byte;
    assign token_first = head.token_first;
    assign token_last  = head.token_last;
    assign line_number = head.line_number;
    assign text_done   = head.text_done;

endmodule

/* rtl/style_text_tokenizer_top.sv */
// Channel    Direction  Handshake              Payload
// text in    input      push / full            text_byte
// tokens     output     empty / pop            token_byte, token_first, token_last,
//                                              line_number, text_done
// config     input      cfg_write (no stall)   cfg_index, cfg_data
//
// One text byte is accepted per cycle while the classify queue has room.
// An accepted byte is registered in the classify queue before the scanner takes it;
// its results, zero to two of them, pass through the result queue to the ports.
// The scanner handles one byte per cycle; it waits only when the result queue
// lacks room for what the byte produces; results drain at one per cycle on pop.
// Reset restores both special-symbol bitmaps, line 1 and an empty scanner.
module style_text_tokenizer_top #(
    parameter int LINE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    input  logic [7:0]  text_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  token_byte,
    output logic        token_first,
    output logic        token_last,
    output logic [15:0] line_number,
    output logic        text_done
);

    // The front stage owns the configuration bitmaps and tags every byte with
    // its class, so the scanner only needs narrow flags to make decisions.
    logic            cls_valid;
    logic            cls_pop;
    stt_pkg::class_t cls_item;

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .text_byte (text_byte),
        .full      (full),
        .cls_valid (cls_valid),
        .cls_item  (cls_item),
        .cls_pop   (cls_pop)
    );

    // The back stage holds one byte as lookahead, tracks comments and lines,
    // and writes its results into a small queue that feeds the result ports.
    stt_back #(
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cls_valid   (cls_valid),
        .cls_item    (cls_item),
        .cls_pop     (cls_pop),
        .empty       (empty),
        .pop         (pop),
        .token_byte  (token_byte),
        .token_first (token_first),
        .token_last  (token_last),
        .line_number (line_number),
        .text_done   (text_done)
    );

`ifndef SYNTHESIS
    // An accepted byte is waiting for the scanner at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> cls_valid)
    else $error("accepted byte missing from classify queue");

    // The end-of-text item carries no token byte or marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> (token_byte == 8'h00 && !token_first && !token_last))
    else $error("end-of-text item carries token data");

    // Lines are counted from one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (line_number != 16'h0000))
    else $error("line number is zero");

    // The scanner only takes a byte that the front has queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        cls_pop |-> cls_valid)
    else $error("scanner consumed from an empty classify queue");
`endif

endmodule

/* test/style_text_tokenizer_top_test.sv */
module style_text_tokenizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The line counter of the block is as wide as the output port.
    localparam int          LINE_BITS       = 16;
    localparam int unsigned LINE_MAX        = (32'd1 << LINE_BITS) - 1;
    // The hold-off is long enough to fill both internal queues many times over.
    localparam int          HOLD_OFF_CYCLES = 400;
    // Even with two results per byte and the longest gaps on both sides, a
    // correct run stays below this limit.
    localparam int          CYCLE_LIMIT     = 2_000_000;
    localparam int          PHASE_ITEMS     = 210;
    localparam stt_pkg::res_t NO_RES        = '0;

    // One row of the directed script. When known is -1 the expected results
    // come from the predictor, otherwise the first known results below are used.
    typedef struct {
        logic [7:0]    text;
        int            known;
        stt_pkg::res_t first_res;
        stt_pkg::res_t second_res;
    } script_row_t;

    // Every input of the block starts at a known value before any process runs.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_write   = 1'b0;
    logic        cfg_index   = stt_pkg::REG_SPECIAL_LOW;
    logic [63:0] cfg_data    = '0;
    logic        push        = 1'b0;
    logic [7:0]  text_byte   = '0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  token_byte;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;
    logic        text_done;

    style_text_tokenizer_top #(
        .LINE_BITS(LINE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .text_byte(text_byte),
        .full(full),
        .empty(empty),
        .pop(pop),
        .token_byte(token_byte),
        .token_first(token_first),
        .token_last(token_last),
        .line_number(line_number),
        .text_done(text_done)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Shared run state. The token queue holds the results still owed by the
    // block, oldest first.
    stt_pkg::res_t token_queue [$];
    int   cycles       = 0;
    int   mismatches   = 0;
    int   bytes_sent   = 0;
    bit   tx_steady    = 1'b0;
    bit   rx_steady    = 1'b0;
    bit   hold_off_req = 1'b0;

    // ------------------------------------------------------------------
    // Tokenizer predictor. It keeps its own copy of the symbol maps and of
    // the scanner state, and each call to tokenize_byte leaves the results
    // of one text byte in step_out[0 .. step_n-1].
    // ------------------------------------------------------------------
    logic [63:0]   spec_lo = stt_pkg::SPECIAL_LOW_RESET;
    logic [63:0]   spec_hi = stt_pkg::SPECIAL_HIGH_RESET;
    logic [7:0]    hold_byte;
    bit            hold_valid;
    bit            hold_first;
    bit            in_word;
    bit            in_line_cmt;
    bit            in_block_cmt;
    bit            star_prev;
    bit            slash_wait;
    bit            end_wait;
    int unsigned   line_cnt = 1;
    stt_pkg::res_t step_out [2];
    int            step_n;

    function automatic bit is_symbol(input logic [7:0] b);
        if (b < 8'd64)
            return spec_lo[b[5:0]];
        if (b < 8'd128)
            return spec_hi[b[5:0]];
        return 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == stt_pkg::CH_SPACE || (b >= stt_pkg::CH_TAB && b <= stt_pkg::CH_CR);
    endfunction

    // At most two results leave per byte; the end-of-text result waits a
    // byte when both places are taken.
    function automatic void emit(input logic [7:0] b, input bit f, input bit l, input bit d);
        if (step_n < 2)
        begin
            step_out[step_n] = '{token_byte: b, token_first: f, token_last: l,
                                 line_number: line_cnt[15:0], text_done: d};
            step_n++;
        end
    endfunction

    function automatic void count_line();
        if (line_cnt < LINE_MAX)
            line_cnt++;
    endfunction

    function automatic void restart_scan();
        hold_byte    = '0;
        hold_valid   = 1'b0;
        hold_first   = 1'b0;
        in_word      = 1'b0;
        in_line_cmt  = 1'b0;
        in_block_cmt = 1'b0;
        star_prev    = 1'b0;
        slash_wait   = 1'b0;
        end_wait     = 1'b0;
        line_cnt     = 1;
    endfunction

    function automatic void close_word();
        if (hold_valid)
            emit(hold_byte, hold_first, 1'b1, 1'b0);
        hold_valid = 1'b0;
        in_word    = 1'b0;
    endfunction

    // The held byte ends its token unless it is a word byte followed by
    // another word byte.
    function automatic void extend_word(input logic [7:0] b);
        bit f;
        f = !(hold_valid && in_word);
        if (hold_valid)
            emit(hold_byte, hold_first, !in_word, 1'b0);
        hold_byte  = b;
        hold_first = f;
        in_word    = 1'b1;
        hold_valid = 1'b1;
    endfunction

    function automatic void scan_plain(input logic [7:0] b);
        if (b == 8'h00)
        begin
            close_word();
            end_wait = 1'b1;
        end
        else if (is_symbol(b))
        begin
            close_word();
            if (b == stt_pkg::CH_NEWLINE)
                count_line();
            hold_byte  = b;
            hold_first = 1'b1;
            in_word    = 1'b0;
            hold_valid = 1'b1;
        end
        else if (is_blank(b))
        begin
            close_word();
            if (b == stt_pkg::CH_NEWLINE)
                count_line();
        end
        else if (b == stt_pkg::CH_SLASH)
            slash_wait = 1'b1;
        else
            extend_word(b);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        step_n = 0;
        // An end-of-text result left over from the last byte goes first.
        if (end_wait)
        begin
            emit(8'h00, 1'b0, 1'b0, 1'b1);
            restart_scan();
        end
        if (in_line_cmt)
        begin
            if (b == 8'h00)
                end_wait = 1'b1;
            else if (b == stt_pkg::CH_NEWLINE)
            begin
                count_line();
                in_line_cmt = 1'b0;
            end
        end
        else if (in_block_cmt)
        begin
            if (b == 8'h00)
                end_wait = 1'b1;
            else if (b == stt_pkg::CH_NEWLINE)
            begin
                count_line();
                star_prev = 1'b0;
            end
            else if (star_prev && b == stt_pkg::CH_SLASH)
            begin
                in_block_cmt = 1'b0;
                star_prev    = 1'b0;
            end
            else
                star_prev = (b == stt_pkg::CH_STAR);
        end
        else if (slash_wait)
        begin
            // A slash opens a comment only when the next byte completes the
            // opener; otherwise it becomes a word byte.
            slash_wait = 1'b0;
            if (b == stt_pkg::CH_SLASH)
            begin
                close_word();
                in_line_cmt = 1'b1;
            end
            else if (b == stt_pkg::CH_STAR)
            begin
                close_word();
                in_block_cmt = 1'b1;
                star_prev    = 1'b0;
            end
            else
            begin
                extend_word(stt_pkg::CH_SLASH);
                scan_plain(b);
            end
        end
        else
            scan_plain(b);
        if (end_wait && step_n < 2)
        begin
            emit(8'h00, 1'b0, 1'b0, 1'b1);
            restart_scan();
        end
    endfunction

    function automatic stt_pkg::res_t token_res(input logic [7:0] b, input bit f,
                                                input bit l, input logic [15:0] ln,
                                                input bit d);
        return '{token_byte: b, token_first: f, token_last: l, line_number: ln, text_done: d};
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[cycle %0d] token mismatch: %s", cycles, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Random idle lengths: mostly none, often a few cycles, rarely a long gap.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pops come at random, or steadily under rx_steady. A hold-off request
    // from the sender side turns into a long stretch without pops, counted here.
    initial
    begin : token_sink
        stt_pkg::res_t want;
        int            stall_left;
        stall_left = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (token_queue.size() == 0)
                    report_mismatch($sformatf("result 0x%02h arrived with nothing expected",
                                              token_byte));
                else
                begin
                    want = token_queue.pop_front();
                    check_field("token_byte", 16'(token_byte), 16'(want.token_byte));
                    check_field("token_first", 16'(token_first), 16'(want.token_first));
                    check_field("token_last", 16'(token_last), 16'(want.token_last));
                    check_field("line_number", line_number, want.line_number);
                    check_field("text_done", 16'(text_done), 16'(want.text_done));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (rx_steady)
                pop <= 1'b1;
            else
            begin
                stall_left = idle_cycles();
                if (stall_left == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    stall_left--;
                end
            end
        end
    end

    // The run ends with a failure if it goes on far longer than any correct run.
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Text side.
    // ------------------------------------------------------------------

    // Offers one text byte, waits until the block takes it and records what
    // it must produce. Rows of the directed script may give the results
    // outright; the predictor still steps so that its state keeps up.
    task automatic push_byte(input logic [7:0] b, input int known, input stt_pkg::res_t r0,
                             input stt_pkg::res_t r1);
        int gap;
        gap = tx_steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_byte <= b;
        push      <= 1'b1;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        tokenize_byte(b);
        if (known < 0)
        begin
            for (int i = 0; i < step_n; i++)
                token_queue.push_back(step_out[i]);
        end
        else
        begin
            if (known > 0)
                token_queue.push_back(r0);
            if (known > 1)
                token_queue.push_back(r1);
        end
    endtask

    task automatic put_text(input logic [7:0] b);
        push_byte(b, -1, NO_RES, NO_RES);
    endtask

    // Stops offering bytes, lets every owed result arrive and then waits for
    // the block to settle any byte that produced nothing.
    task automatic wait_idle();
        push <= 1'b0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Both maps are written on back-to-back edges, so the write enable
    // stays high between them.
    task automatic load_specials(input logic [63:0] lo, input logic [63:0] hi);
        cfg_write <= 1'b1;
        cfg_index <= stt_pkg::REG_SPECIAL_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        spec_lo = lo;
        cfg_index <= stt_pkg::REG_SPECIAL_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        spec_hi = hi;
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 85)
            return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] blank_char();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? stt_pkg::CH_SPACE : 8'(v);
    endfunction

    // Block comment bodies lean toward the bytes that can close or confuse a
    // comment. A line comment body never holds a newline.
    function automatic logic [7:0] comment_char(input bit block);
        int r;
        logic [7:0] b;
        if (!block)
        begin
            b = 8'($urandom_range(1, 254));
            return (b >= stt_pkg::CH_NEWLINE) ? b + 8'd1 : b;
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            return stt_pkg::CH_STAR;
        if (r < 25)
            return stt_pkg::CH_SLASH;
        if (r < 35)
            return stt_pkg::CH_NEWLINE;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_word(input int len);
        repeat (len) put_text(word_char());
    endtask

    // One piece of text: mostly well-formed words, symbols, blanks and
    // comments, with lone slashes, stray bytes, text ends and comments left
    // open at the end of text mixed in.
    task automatic send_fragment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_word($urandom_range(1, 8));
        else if (pick < 42)
            repeat ($urandom_range(1, 3)) put_text(blank_char());
        else if (pick < 54)
            put_text(8'($urandom_range(1, 127)));
        else if (pick < 62)
        begin
            send_word($urandom_range(1, 4));
            put_text(stt_pkg::CH_SLASH);
            send_word($urandom_range(1, 4));
        end
        else if (pick < 70)
        begin
            put_text(stt_pkg::CH_SLASH);
            put_text(stt_pkg::CH_SLASH);
            repeat ($urandom_range(0, 10)) put_text(comment_char(1'b0));
            put_text(stt_pkg::CH_NEWLINE);
        end
        else if (pick < 80)
        begin
            put_text(stt_pkg::CH_SLASH);
            put_text(stt_pkg::CH_STAR);
            repeat ($urandom_range(0, 12)) put_text(comment_char(1'b1));
            put_text(stt_pkg::CH_STAR);
            put_text(stt_pkg::CH_SLASH);
        end
        else if (pick < 88)
            put_text(8'($urandom_range(1, 255)));
        else if (pick < 92)
        begin
            put_text(stt_pkg::CH_SLASH);
            put_text(8'($urandom_range(1, 255)));
        end
        else if (pick < 96)
        begin
            // Sometimes a word ends in a slash right at the end of text.
            if ($urandom_range(0, 1) == 1)
            begin
                send_word($urandom_range(1, 4));
                put_text(stt_pkg::CH_SLASH);
            end
            put_text(8'h00);
        end
        else
        begin
            put_text(stt_pkg::CH_SLASH);
            put_text(($urandom_range(0, 1) == 1) ? stt_pkg::CH_SLASH : stt_pkg::CH_STAR);
            repeat ($urandom_range(0, 5)) put_text(8'($urandom_range(1, 255)));
            put_text(8'h00);
        end
    endtask

    // A phase starts from an idle block, loads both symbol maps and then
    // streams random text.
    task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi, input int n,
                             input bit tx_flat, input bit rx_flat, input bit hold);
        int start;
        wait_idle();
        load_specials(lo, hi);
        tx_steady = tx_flat;
        rx_steady = rx_flat;
        if (hold)
            hold_off_req = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < n)
            send_fragment();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin : stimulus
        script_row_t script [24];

        // Directed script under the reset symbol maps, where ';', ':', ',',
        // '{' and '}' are symbols. It walks a symbol, a slash inside a word,
        // a line comment, a block comment whose opening star cannot close it,
        // the highest byte values, blanks, a word ending in a slash at the end
        // of text and a second text right after the first.
        script = '{
            '{8'h7B,               -1, NO_RES, NO_RES},
            '{8'h61,                1, token_res(8'h7B, 1'b1, 1'b1, 16'd1, 1'b0), NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{8'h62,               -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{8'h78,               -1, NO_RES, NO_RES},
            '{stt_pkg::CH_NEWLINE, -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{stt_pkg::CH_STAR,    -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{stt_pkg::CH_NEWLINE, -1, NO_RES, NO_RES},
            '{stt_pkg::CH_STAR,    -1, NO_RES, NO_RES},
            '{stt_pkg::CH_STAR,    -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{8'hFF,               -1, NO_RES, NO_RES},
            '{8'h80,                1, token_res(8'hFF, 1'b1, 1'b0, 16'd3, 1'b0), NO_RES},
            '{stt_pkg::CH_SPACE,    1, token_res(8'h80, 1'b0, 1'b1, 16'd3, 1'b0), NO_RES},
            '{stt_pkg::CH_TAB,     -1, NO_RES, NO_RES},
            '{8'h7F,               -1, NO_RES, NO_RES},
            '{stt_pkg::CH_SLASH,   -1, NO_RES, NO_RES},
            '{8'h00,                2, token_res(8'h7F, 1'b1, 1'b0, 16'd3, 1'b0),
                                       token_res(stt_pkg::CH_SLASH, 1'b0, 1'b1, 16'd3, 1'b0)},
            '{8'h3B,                1, token_res(8'h00, 1'b0, 1'b0, 16'd3, 1'b1), NO_RES},
            '{8'h00,                2, token_res(8'h3B, 1'b1, 1'b1, 16'd1, 1'b0),
                                       token_res(8'h00, 1'b0, 1'b0, 16'd1, 1'b1)}
        };

        restart_scan();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            push_byte(script[i].text, script[i].known, script[i].first_res,
                      script[i].second_res);

        // No symbols at all, then every low byte a symbol, slash and star
        // included, so that comments can never open.
        run_phase('0, '0, PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        run_phase('1, '1, PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        // Everything but the slash is a symbol: comment openers whose second
        // byte is a symbol, and symbol newlines reporting the line they open.
        run_phase(~(64'd1 << stt_pkg::CH_SLASH), '1, PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        // Newline and space as symbols, and a long receiver hold-off while the
        // sender keeps pushing, so the block fills up and stalls its input.
        run_phase({$urandom, $urandom} | (64'd1 << stt_pkg::CH_NEWLINE) |
                  (64'd1 << stt_pkg::CH_SPACE),
                  {$urandom, $urandom}, PHASE_ITEMS, 1'b1, 1'b0, 1'b1);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, PHASE_ITEMS, 1'b1, 1'b1, 1'b0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        run_phase(stt_pkg::SPECIAL_LOW_RESET, stt_pkg::SPECIAL_HIGH_RESET, PHASE_ITEMS,
                  1'b0, 1'b0, 1'b0);

        // Close the last text so no result stays inside the block.
        put_text(stt_pkg::CH_SPACE);
        put_text(8'h00);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
